>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character helpers of the source text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int POS_BITS = 20;
  localparam int OUT_BITS = 20;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [OUT_BITS-1:0] field_t;

  // token kinds
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_IDENT    = 5'd1;
  localparam logic [4:0] KIND_INT      = 5'd2;
  localparam logic [4:0] KIND_FLOAT    = 5'd3;
  localparam logic [4:0] KIND_STRING   = 5'd4;
  localparam logic [4:0] KIND_CHAR     = 5'd5;
  localparam logic [4:0] KIND_PLUS     = 5'd6;
  localparam logic [4:0] KIND_PLUS_EQ  = 5'd7;
  localparam logic [4:0] KIND_MINUS    = 5'd8;
  localparam logic [4:0] KIND_MINUS_EQ = 5'd9;
  localparam logic [4:0] KIND_STAR     = 5'd10;
  localparam logic [4:0] KIND_STAR_EQ  = 5'd11;
  localparam logic [4:0] KIND_AND      = 5'd12;
  localparam logic [4:0] KIND_LBRACE   = 5'd13;
  localparam logic [4:0] KIND_RBRACE   = 5'd14;
  localparam logic [4:0] KIND_LBRACK   = 5'd15;
  localparam logic [4:0] KIND_RBRACK   = 5'd16;
  localparam logic [4:0] KIND_LPAREN   = 5'd17;
  localparam logic [4:0] KIND_RPAREN   = 5'd18;
  localparam logic [4:0] KIND_ASSIGN   = 5'd19;
  localparam logic [4:0] KIND_SEMI     = 5'd20;
  localparam logic [4:0] KIND_COMMA    = 5'd21;
  localparam logic [4:0] KIND_SLASH    = 5'd22;
  localparam logic [4:0] KIND_PERCENT  = 5'd23;
  localparam logic [4:0] KIND_DOT      = 5'd24;
  localparam logic [4:0] KIND_LESS     = 5'd25;
  localparam logic [4:0] KIND_GREATER  = 5'd26;
  localparam logic [4:0] KIND_LAST     = KIND_GREATER;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_CHAR_LONG  = 2'd2;
  localparam logic [1:0] ERR_UNTERM     = 2'd3;

  // characters
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  typedef struct packed {
    logic [4:0] kind;
    field_t     offset;
    field_t     length;
    field_t     line;
    logic [1:0] err;
  } rec_t;

  // all records caused by one byte
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [2:0]      recs;
  } grp_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  // single-character punctuators, end kind when the byte is none of them
  function automatic logic [4:0] punct_kind(logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h7b:   k = KIND_LBRACE;
      8'h7d:   k = KIND_RBRACE;
      8'h5b:   k = KIND_LBRACK;
      8'h5d:   k = KIND_RBRACK;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3d:   k = KIND_ASSIGN;
      8'h3b:   k = KIND_SEMI;
      8'h2c:   k = KIND_COMMA;
      8'h2f:   k = KIND_SLASH;
      8'h25:   k = KIND_PERCENT;
      8'h2e:   k = KIND_DOT;
      8'h3c:   k = KIND_LESS;
      8'h3e:   k = KIND_GREATER;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic field_t sat_field(pos_t v);
    logic [POS_BITS+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, v};
    if (w > {{POS_BITS{1'b0}}, {OUT_BITS{1'b1}}}) begin
      return {OUT_BITS{1'b1}};
    end
    return w[OUT_BITS-1:0];
  endfunction

  function automatic rec_t mk_rec(logic [4:0] kind, pos_t off, pos_t len, pos_t line,
                                  logic [1:0] err);
    rec_t r;
    r.kind   = kind;
    r.offset = sat_field(off);
    r.length = sat_field(len);
    r.line   = sat_field(line);
    r.err    = err;
    return r;
  endfunction

  function automatic grp_t add_rec(grp_t g, rec_t r);
    grp_t o;
    o = g;
    if (g.cnt < 2'd3) begin
      o.recs[g.cnt] = r;
      o.cnt         = g.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/stt_in_if.sv
// ----------------------------------------------------------------------------
// stt_in_if
// Text byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stt_out_if.sv
// ----------------------------------------------------------------------------
// stt_out_if
// Token record channel: valid/ready handshake with one token record.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [19:0] start_offset;
  logic [19:0] token_length;
  logic [19:0] start_line;
  logic [1:0]  error_code;
  logic        run_end;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output start_line, output error_code,
                  output run_end, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input start_line, input error_code,
                  input run_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one byte per cycle unless the queue is full, updates the
// scan mode and counters and queues the records that byte causes as one group.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    text_byte,
  input  wire logic          final_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output stt_pkg::grp_t      q_data
);

  localparam logic [3:0] MODE_IDLE   = 4'd0;
  localparam logic [3:0] MODE_IDENT  = 4'd1;
  localparam logic [3:0] MODE_INT    = 4'd2;
  localparam logic [3:0] MODE_FLOAT  = 4'd3;
  localparam logic [3:0] MODE_PLUS   = 4'd4;
  localparam logic [3:0] MODE_MINUS  = 4'd5;
  localparam logic [3:0] MODE_STAR   = 4'd6;
  localparam logic [3:0] MODE_AMP    = 4'd7;
  localparam logic [3:0] MODE_STRING = 4'd8;
  localparam logic [3:0] MODE_CHAR   = 4'd9;
  localparam logic [3:0] MODE_SKIP   = 4'd10;

  logic [3:0]    mode, mode_next;
  stt_pkg::pos_t byte_pos, byte_pos_next;
  stt_pkg::pos_t pend_start, pend_start_next;
  stt_pkg::pos_t line_count, line_count_next;
  stt_pkg::pos_t pend_line, pend_line_next;
  logic          lit_chars, lit_chars_next;
  stt_pkg::grp_t grp;
  logic          accept;

  function automatic stt_pkg::pos_t span(stt_pkg::pos_t end_pos, stt_pkg::pos_t start_pos);
    return (end_pos >= start_pos) ? end_pos - start_pos : '0;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (grp.cnt != 2'd0);
  assign q_data   = grp;

  always_comb begin
    logic          to_idle;
    logic [4:0]    op_kind;
    logic [4:0]    pk;
    stt_pkg::pos_t sp;
    stt_pkg::pos_t b_pos;
    stt_pkg::pos_t l_cnt;

    mode_next       = mode;
    pend_start_next = pend_start;
    pend_line_next  = pend_line;
    lit_chars_next  = lit_chars;
    grp             = '0;
    to_idle         = 1'b0;
    sp              = span(byte_pos, pend_start);
    b_pos           = byte_pos;
    l_cnt           = line_count;
    op_kind         = stt_pkg::KIND_PLUS;
    pk              = stt_pkg::punct_kind(text_byte);

    unique case (mode)
      MODE_IDENT: begin
        if (!(stt_pkg::is_letter(text_byte) || stt_pkg::is_digit(text_byte) ||
              text_byte == stt_pkg::CH_UNDER)) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_IDENT, pend_start, sp,
                                                      pend_line, stt_pkg::ERR_NONE));
          to_idle = 1'b1;
        end
      end
      MODE_INT: begin
        if (text_byte == stt_pkg::CH_DOT) begin
          mode_next = MODE_FLOAT;
        end else if (!stt_pkg::is_digit(text_byte)) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_INT, pend_start, sp,
                                                      pend_line, stt_pkg::ERR_NONE));
          to_idle = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (!stt_pkg::is_digit(text_byte)) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_FLOAT, pend_start, sp,
                                                      pend_line, stt_pkg::ERR_NONE));
          to_idle = 1'b1;
        end
      end
      MODE_PLUS, MODE_MINUS, MODE_STAR: begin
        if (mode == MODE_MINUS) begin
          op_kind = stt_pkg::KIND_MINUS;
        end else if (mode == MODE_STAR) begin
          op_kind = stt_pkg::KIND_STAR;
        end
        if (text_byte == stt_pkg::CH_EQ) begin
          // the compound form always follows its single-character kind
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(op_kind + 5'd1, pend_start,
                                                      stt_pkg::POS_BITS'(2), pend_line,
                                                      stt_pkg::ERR_NONE));
          mode_next = MODE_IDLE;
        end else begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(op_kind, pend_start,
                                                      stt_pkg::POS_BITS'(1), pend_line,
                                                      stt_pkg::ERR_NONE));
          to_idle = 1'b1;
        end
      end
      MODE_AMP: begin
        if (text_byte == stt_pkg::CH_AMP) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_AND, pend_start,
                                                      stt_pkg::POS_BITS'(2), pend_line,
                                                      stt_pkg::ERR_NONE));
          mode_next = MODE_IDLE;
        end else begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, pend_start, '0,
                                                      pend_line, stt_pkg::ERR_UNEXPECTED));
          mode_next = MODE_SKIP;
        end
      end
      MODE_STRING: begin
        if (text_byte == stt_pkg::CH_DQUOTE) begin
          // body length leaves out the opening quote
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_STRING, pend_start,
                                                      (sp != '0) ? sp - stt_pkg::POS_BITS'(1)
                                                                 : sp,
                                                      pend_line, stt_pkg::ERR_NONE));
          mode_next = MODE_IDLE;
        end
      end
      MODE_CHAR: begin
        if (text_byte == stt_pkg::CH_SQUOTE) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_CHAR, pend_start,
                                                      stt_pkg::POS_BITS'(lit_chars),
                                                      pend_line, stt_pkg::ERR_NONE));
          mode_next = MODE_IDLE;
        end else if (lit_chars) begin
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, pend_start, '0,
                                                      pend_line, stt_pkg::ERR_CHAR_LONG));
          mode_next = MODE_SKIP;
        end else begin
          lit_chars_next = 1'b1;
        end
      end
      MODE_SKIP: begin
      end
      default: begin
        to_idle = 1'b1;
      end
    endcase

    // the byte that closed a token may open the next one
    if (to_idle) begin
      mode_next = MODE_IDLE;
      priority if (text_byte == stt_pkg::CH_SPACE || text_byte == stt_pkg::CH_NL) begin
      end else if (stt_pkg::is_digit(text_byte)) begin
        mode_next = MODE_INT;
      end else if (stt_pkg::is_letter(text_byte)) begin
        mode_next = MODE_IDENT;
      end else if (text_byte == stt_pkg::CH_PLUS) begin
        mode_next = MODE_PLUS;
      end else if (text_byte == stt_pkg::CH_MINUS) begin
        mode_next = MODE_MINUS;
      end else if (text_byte == stt_pkg::CH_STAR) begin
        mode_next = MODE_STAR;
      end else if (text_byte == stt_pkg::CH_AMP) begin
        mode_next = MODE_AMP;
      end else if (text_byte == stt_pkg::CH_DQUOTE) begin
        mode_next = MODE_STRING;
      end else if (text_byte == stt_pkg::CH_SQUOTE) begin
        mode_next      = MODE_CHAR;
        lit_chars_next = 1'b0;
      end else if (pk != stt_pkg::KIND_END) begin
        grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(pk, byte_pos, stt_pkg::POS_BITS'(1),
                                                    line_count, stt_pkg::ERR_NONE));
      end else begin
        grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, byte_pos, '0,
                                                    line_count, stt_pkg::ERR_UNEXPECTED));
        mode_next = MODE_SKIP;
      end
      if (mode_next != MODE_IDLE && mode_next != MODE_SKIP) begin
        pend_start_next = byte_pos;
        pend_line_next  = line_count;
      end
    end

    if (text_byte == stt_pkg::CH_NL && line_count != '1) begin
      l_cnt = line_count + stt_pkg::POS_BITS'(1);
    end
    if (byte_pos != '1) begin
      b_pos = byte_pos + stt_pkg::POS_BITS'(1);
    end
    byte_pos_next   = b_pos;
    line_count_next = l_cnt;

    if (final_byte) begin
      sp = span(b_pos, pend_start_next);
      unique case (mode_next)
        MODE_IDENT:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_IDENT, pend_start_next,
                                                      sp, pend_line_next, stt_pkg::ERR_NONE));
        MODE_INT:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_INT, pend_start_next,
                                                      sp, pend_line_next, stt_pkg::ERR_NONE));
        MODE_FLOAT:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_FLOAT, pend_start_next,
                                                      sp, pend_line_next, stt_pkg::ERR_NONE));
        MODE_PLUS:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_PLUS, pend_start_next,
                                                      stt_pkg::POS_BITS'(1), pend_line_next,
                                                      stt_pkg::ERR_NONE));
        MODE_MINUS:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_MINUS, pend_start_next,
                                                      stt_pkg::POS_BITS'(1), pend_line_next,
                                                      stt_pkg::ERR_NONE));
        MODE_STAR:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_STAR, pend_start_next,
                                                      stt_pkg::POS_BITS'(1), pend_line_next,
                                                      stt_pkg::ERR_NONE));
        MODE_AMP:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, pend_start_next, '0,
                                                      pend_line_next,
                                                      stt_pkg::ERR_UNEXPECTED));
        MODE_STRING, MODE_CHAR:
          grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, pend_start_next, '0,
                                                      pend_line_next, stt_pkg::ERR_UNTERM));
        default: begin
        end
      endcase
      grp = stt_pkg::add_rec(grp, stt_pkg::mk_rec(stt_pkg::KIND_END, b_pos, '0, l_cnt,
                                                  stt_pkg::ERR_NONE));
      // back to the start of a fresh text
      mode_next       = MODE_IDLE;
      byte_pos_next   = '0;
      pend_start_next = '0;
      line_count_next = stt_pkg::POS_BITS'(1);
      pend_line_next  = stt_pkg::POS_BITS'(1);
      lit_chars_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      byte_pos   <= '0;
      pend_start <= '0;
      line_count <= stt_pkg::POS_BITS'(1);
      pend_line  <= stt_pkg::POS_BITS'(1);
      lit_chars  <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      byte_pos   <= byte_pos_next;
      pend_start <= pend_start_next;
      line_count <= line_count_next;
      pend_line  <= pend_line_next;
      lit_chars  <= lit_chars_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Two-entry queue of record groups between the scanner and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire stt_pkg::grp_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output stt_pkg::grp_t      head
);

  stt_pkg::grp_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Serializer: sends the records of the head group one per handshake and
// marks the last record of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire stt_pkg::grp_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output stt_pkg::rec_t      out_rec,
  output logic               out_last
);

  logic [1:0] idx;
  logic       last;
  logic       take;

  assign out_valid = !q_empty;
  assign out_rec   = q_head.recs[idx];
  assign last      = (idx == q_head.cnt - 2'd1);
  assign out_last  = last;
  assign take      = out_valid && out_ready;
  assign q_pop     = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream lexer producing token records with offset, length and line.
// ----------------------------------------------------------------------------
// Usage:
//   text_in takes one source byte per request, final_byte set on the last
//   byte of a text. token_out gives one token record per request; run_end
//   marks the last record caused by one byte.
//   A byte is taken in the cycle it is offered while the two-entry group
//   queue has room, so the input runs at one byte per cycle. The records of
//   a byte can be taken from the cycle after it was accepted; one record
//   leaves per cycle when not stalled, so a byte causing k records holds the
//   output until all k have left and the scanner runs ahead until the group
//   queue fills. Bytes causing no record (inside a token, blanks) queue nothing.
//   Reset clears the scan mode, counters and queue; offsets start at 0 and
//   lines at 1. After the final byte the scanner returns to the same state.
//   When the receiver stalls, the head record holds and text_in drops ready
//   once two groups wait.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer (
  input  wire logic   clk,
  input  wire logic   rst,
  stt_in_if.sink      text_in,
  stt_out_if.source   token_out
);

  logic          q_full;
  logic          q_push;
  stt_pkg::grp_t q_data;
  logic          q_pop;
  logic          q_empty;
  stt_pkg::grp_t q_head;
  stt_pkg::rec_t rec;
  logic          rec_last;

  stt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (text_in.valid),
    .in_ready   (text_in.ready),
    .text_byte  (text_in.text_byte),
    .final_byte (text_in.final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  stt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_rec   (rec),
    .out_last  (rec_last)
  );

  assign token_out.token_kind   = rec.kind;
  assign token_out.start_offset = rec.offset;
  assign token_out.token_length = rec.length;
  assign token_out.start_line   = rec.line;
  assign token_out.error_code   = rec.err;
  assign token_out.run_end      = rec_last;

endmodule

`default_nettype wire

>>> rtl/core/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  token_kind,
  input wire logic [19:0] start_offset,
  input wire logic [19:0] token_length,
  input wire logic [19:0] start_line,
  input wire logic [1:0]  error_code,
  input wire logic        run_end
);

  // queue is empty right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
      out_valid && error_code != stt_pkg::ERR_NONE
      |-> token_kind == stt_pkg::KIND_END && token_length == 20'd0)
    else $error("error record with kind or length set");

  // the end record always closes its byte's group
  a_end_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && token_kind == stt_pkg::KIND_END && error_code == stt_pkg::ERR_NONE
      |-> run_end)
    else $error("end record not marked last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> token_kind <= stt_pkg::KIND_LAST)
    else $error("token kind out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready
      |=> out_valid && $stable(token_kind) && $stable(start_offset) &&
          $stable(token_length) && $stable(start_line) && $stable(error_code) &&
          $stable(run_end))
    else $error("stalled record changed");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (token_out.valid),
  .out_ready    (token_out.ready),
  .token_kind   (token_out.token_kind),
  .start_offset (token_out.start_offset),
  .token_length (token_out.token_length),
  .start_line   (token_out.start_line),
  .error_code   (token_out.error_code),
  .run_end      (token_out.run_end)
);

`default_nettype wire
